// File: rtl/gfd_pkg.sv
package gfd_pkg;

  localparam logic [7:0] SyncFirst  = 8'hA0;
  localparam logic [7:0] SyncSecond = 8'hA2;
  localparam logic [7:0] EndFirst   = 8'hB0;
  localparam logic [7:0] EndSecond  = 8'hB3;

  localparam int unsigned LenW = 15;
  localparam logic [LenW-1:0] MaxLenReset = 15'd1023;

  // Both queue depths must be powers of two: pointers wrap on overflow.
  localparam int unsigned TokDepth = 4;
  localparam int unsigned TokPtrW  = $clog2(TokDepth);
  localparam int unsigned ResDepth = 2;
  localparam int unsigned ResPtrW  = $clog2(ResDepth);

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_DONE   = 2'd1,
    KIND_BADLEN = 2'd2,
    KIND_BADEND = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    PH_HUNT0,
    PH_HUNT1,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_PAYLOAD,
    PH_CK0,
    PH_CK1,
    PH_END0,
    PH_END1
  } phase_e;

  // Byte with its marker matches, produced by the front end.
  typedef struct packed {
    logic [7:0] data;
    logic       sync_first;
    logic       sync_second;
    logic       end_first;
    logic       end_second;
  } tok_t;

  typedef struct packed {
    kind_e           kind;
    logic [7:0]      data;
    logic [LenW-1:0] index;
    logic            first;
    logic            last;
    logic [LenW-1:0] len;
  } res_t;

endpackage

// File: rtl/gfd_front.sv
module gfd_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  logic [7:0]    rx_byte_i,
  input  logic          from_gps_i,
  output gfd_pkg::tok_t tok_o,
  output logic          tok_valid_o,
  input  logic          tok_pop_i
);
  import gfd_pkg::*;

  tok_t               mem_q [TokDepth];
  tok_t               tok_in;
  logic [TokPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [TokPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [TokPtrW:0]   count_q, count_d;
  logic               wr_en, rd_en;

  assign full        = (count_q == (TokPtrW+1)'(TokDepth));
  assign tok_valid_o = (count_q != '0);
  assign tok_o       = mem_q[rd_ptr_q];

  // Drop bytes from other sources at the door.
  assign wr_en = push && !full && from_gps_i;
  assign rd_en = tok_pop_i && tok_valid_o;

  always_comb begin
    tok_in.data        = rx_byte_i;
    tok_in.sync_first  = (rx_byte_i == SyncFirst);
    tok_in.sync_second = (rx_byte_i == SyncSecond);
    tok_in.end_first   = (rx_byte_i == EndFirst);
    tok_in.end_second  = (rx_byte_i == EndSecond);
  end

  always_comb begin
    wr_ptr_d = wr_en ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = rd_en ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (wr_en && !rd_en) begin
      count_d = count_q + 1'b1;
    end else if (!wr_en && rd_en) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= tok_in;
    end
  end

endmodule

// File: rtl/gfd_back.sv
module gfd_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  gfd_pkg::tok_t             tok_i,
  input  logic                      tok_valid_i,
  output logic                      tok_pop_o,
  input  logic [gfd_pkg::LenW-1:0]  max_len_i,
  output gfd_pkg::res_t             res_o,
  output logic                      empty,
  input  logic                      pop
);
  import gfd_pkg::*;

  phase_e          phase_q, phase_d;
  logic [6:0]      len_high_q, len_high_d;
  logic            len_big_q, len_big_d;
  logic [LenW-1:0] exp_len_q, exp_len_d;
  logic [LenW-1:0] seen_q, seen_d;

  logic [LenW-1:0] len_full, seen_inc;
  logic            len_bad, last;
  logic            step;
  logic            res_valid;
  res_t            res_new;

  res_t               rq_q [ResDepth];
  logic [ResPtrW-1:0] rq_wr_q, rq_rd_q;
  logic [ResPtrW:0]   rq_count_q, rq_count_d;
  logic               rq_space, rq_wr, rq_rd;

  // Result queue: the parser advances while a slot is free or one leaves now.
  assign empty    = (rq_count_q == '0);
  assign res_o    = rq_q[rq_rd_q];
  assign rq_rd    = pop && !empty;
  assign rq_space = (rq_count_q != (ResPtrW+1)'(ResDepth)) || rq_rd;

  assign tok_pop_o = tok_valid_i && rq_space;
  assign step      = tok_pop_o;

  assign len_full = {len_high_q, tok_i.data};
  assign len_bad  = len_big_q || (len_full == '0) || (len_full > max_len_i);
  assign seen_inc = seen_q + 1'b1;
  assign last     = (seen_inc == exp_len_q);

  // Next state
  always_comb begin
    phase_d    = phase_q;
    len_high_d = len_high_q;
    len_big_d  = len_big_q;
    exp_len_d  = exp_len_q;
    seen_d     = seen_q;
    if (step) begin
      unique case (phase_q)
        PH_HUNT1: begin
          if (tok_i.sync_second) begin
            phase_d = PH_LEN_HI;
          end else if (!tok_i.sync_first) begin
            phase_d = PH_HUNT0;
          end
        end
        PH_LEN_HI: begin
          len_high_d = tok_i.data[6:0];
          len_big_d  = tok_i.data[7];
          phase_d    = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          if (len_bad) begin
            phase_d = PH_HUNT0;
          end else begin
            exp_len_d = len_full;
            seen_d    = '0;
            phase_d   = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          seen_d = seen_inc;
          if (last) begin
            phase_d = PH_CK0;
          end
        end
        PH_CK0: phase_d = PH_CK1;
        PH_CK1: phase_d = PH_END0;
        PH_END0: begin
          phase_d = tok_i.end_first ? PH_END1 : PH_HUNT0;
        end
        PH_END1: phase_d = PH_HUNT0;
        default: begin
          phase_d = tok_i.sync_first ? PH_HUNT1 : PH_HUNT0;
        end
      endcase
    end
  end

  // Outputs
  always_comb begin
    res_valid     = 1'b0;
    res_new.kind  = KIND_DATA;
    res_new.data  = '0;
    res_new.index = '0;
    res_new.first = 1'b0;
    res_new.last  = 1'b0;
    res_new.len   = exp_len_q;
    unique case (phase_q)
      PH_LEN_LO: begin
        res_valid    = len_bad;
        res_new.kind = KIND_BADLEN;
        res_new.len  = len_full;
      end
      PH_PAYLOAD: begin
        res_valid     = 1'b1;
        res_new.data  = tok_i.data;
        res_new.index = seen_q;
        res_new.first = (seen_q == '0);
        res_new.last  = last;
      end
      PH_END0: begin
        res_valid    = !tok_i.end_first;
        res_new.kind = KIND_BADEND;
      end
      PH_END1: begin
        res_valid    = 1'b1;
        res_new.kind = tok_i.end_second ? KIND_DONE : KIND_BADEND;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  assign rq_wr = step && res_valid;

  always_comb begin
    rq_count_d = rq_count_q;
    if (rq_wr && !rq_rd) begin
      rq_count_d = rq_count_q + 1'b1;
    end else if (!rq_wr && rq_rd) begin
      rq_count_d = rq_count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HUNT0;
      len_high_q <= '0;
      len_big_q  <= 1'b0;
      exp_len_q  <= '0;
      seen_q     <= '0;
      rq_wr_q    <= '0;
      rq_rd_q    <= '0;
      rq_count_q <= '0;
    end else begin
      phase_q    <= phase_d;
      len_high_q <= len_high_d;
      len_big_q  <= len_big_d;
      exp_len_q  <= exp_len_d;
      seen_q     <= seen_d;
      rq_count_q <= rq_count_d;
      if (rq_wr) begin
        rq_wr_q <= rq_wr_q + 1'b1;
      end
      if (rq_rd) begin
        rq_rd_q <= rq_rd_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rq_wr) begin
      rq_q[rq_wr_q] <= res_new;
    end
  end

endmodule

// File: rtl/gps_binary_frame_deframer.sv
// GPS binary frame deframer.
// Input: present rx_byte_i/from_gps_i with push; a transaction completes when
// push is high and full is low. Bytes with from_gps_i low are accepted and
// dropped. Results: while empty is low the oldest result sits on item_kind_o
// and the field ports; pop high with empty low completes that transaction.
// One result per payload byte, one at frame end (done or bad end marker),
// one for a rejected length; header, checksum and sync bytes give none.
// A byte passes through the byte queue, the parser and the result queue before
// its result appears on the ports.
// Throughput: one byte per cycle, set by the parser step, while the result queue has room.
// A 4-entry byte queue sits in front of the parser and a 2-entry result
// queue behind it; when the receiver holds off pop the result queue fills,
// the parser holds, the byte queue fills and full rises.
// The max payload length register is written through cfg_valid_i/cfg_wdata_i
// (always ready); write it only while the block is idle.
// Reset: both queues empty, parser hunting for the first start byte,
// max payload length 1023.
module gps_binary_frame_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_byte_i,
  input  logic        from_gps_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  item_kind_o,
  output logic [7:0]  payload_byte_o,
  output logic [14:0] byte_index_o,
  output logic        is_message_id_o,
  output logic        is_last_byte_o,
  output logic [14:0] frame_length_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [14:0] cfg_wdata_i
);
  import gfd_pkg::*;

  logic [LenW-1:0] max_len_q;
  tok_t            tok;
  logic            tok_valid, tok_pop;
  res_t            res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxLenReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_len_q <= cfg_wdata_i;
    end
  end

  gfd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .rx_byte_i  (rx_byte_i),
    .from_gps_i (from_gps_i),
    .tok_o      (tok),
    .tok_valid_o(tok_valid),
    .tok_pop_i  (tok_pop)
  );

  gfd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tok_i      (tok),
    .tok_valid_i(tok_valid),
    .tok_pop_o  (tok_pop),
    .max_len_i  (max_len_q),
    .res_o      (res),
    .empty      (empty),
    .pop        (pop)
  );

  assign item_kind_o     = res.kind;
  assign payload_byte_o  = res.data;
  assign byte_index_o    = res.index;
  assign is_message_id_o = res.first;
  assign is_last_byte_o  = res.last;
  assign frame_length_o  = res.len;

  a_status_fields_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (item_kind_o != KIND_DATA)) |->
      (payload_byte_o == '0) && (byte_index_o == '0) && !is_message_id_o && !is_last_byte_o)
    else $error("status result carries payload fields");

  a_msg_id_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (item_kind_o == KIND_DATA) && is_message_id_o) |-> (byte_index_o == '0))
    else $error("message id not at index zero");

  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (item_kind_o == KIND_DATA) && is_last_byte_o) |->
      (15'(byte_index_o + 15'd1) == frame_length_o))
    else $error("last byte index does not match frame length");

  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (item_kind_o == KIND_DATA)) |->
      (frame_length_o != '0) && (byte_index_o < frame_length_o))
    else $error("payload byte outside frame length");

endmodule
